FILE: rtl/opet_pkg.sv
// Shared types, codes and helper functions for the one-shot/periodic event timer.
package opet_pkg;

    localparam int TIME_W = 64;
    localparam int CNT_W  = $clog2(TIME_W + 1);

    localparam logic [TIME_W-1:0] MIN_PERIOD = TIME_W'(100);

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_INVAL   = 3'd1;
    localparam logic [2:0] STAT_NOTCONN = 3'd2;
    localparam logic [2:0] STAT_BUSY    = 3'd3;
    localparam logic [2:0] STAT_PAST    = 3'd4;

    localparam logic [1:0] CFG_PORT_CONNECTED = 2'd0;
    localparam logic [1:0] CFG_EVENT_SOURCE   = 2'd1;
    localparam logic [1:0] CFG_EVENT_DATA_ONE = 2'd2;
    localparam logic [1:0] CFG_EVENT_DATA_TWO = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_FIRST,
        S_MOD,
        S_ALIGN,
        S_FIXUP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic start;
        logic first;
        logic div_start;
        logic align;
        logic fixup;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic rejected;
        logic need_phase;
        logic now_lt_first;
        logic div_done;
    } stat_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

FILE: rtl/oneshot_periodic_event_timer.sv
// Top level of the one-shot/periodic event timer.
//
// Input channel (s_valid/s_ready): one item per command, carrying the action
// (tick, start, stop, read), the current time and, for start, the base time
// and period. Result channel (m_valid/m_ready): exactly one item per input
// item with the start status, any expiry event raised and the timer state.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 port connected, 1 event source, 2 data word one, 3 data word two).
// Steps: each item is captured, checked and then loaded into the result
// register; a start that passes the period and connection checks first runs
// the start step, a periodic start with a phase base also the first-expiry step,
// and one whose base plus period is not ahead of the current time then the two
// 64-bit bit-serial remainder units in parallel and the align and fixup steps.
// One item is in work at a time; s_ready rises again when its
// result is loaded into the output register, so a new item is taken while
// that result still waits for m_ready. A stalled receiver holds the result
// and, once the next item finishes, holds the block in its result state.
// Reset (aresetn low, synchronous) stops the timer and clears the expiry
// time, period and all configuration registers.
module oneshot_periodic_event_timer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [opet_pkg::TIME_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [opet_pkg::TIME_W-1:0]  s_now_time,
    input  logic [opet_pkg::TIME_W-1:0]  s_base_time,
    input  logic [opet_pkg::TIME_W-1:0]  s_period_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_status,
    output logic                         m_event_fire,
    output logic [opet_pkg::TIME_W-1:0]  m_event_src,
    output logic [opet_pkg::TIME_W-1:0]  m_event_d1,
    output logic [opet_pkg::TIME_W-1:0]  m_event_d2,
    output logic [opet_pkg::TIME_W-1:0]  m_event_time,
    output logic [opet_pkg::TIME_W-1:0]  m_sleep_hint,
    output logic                         m_running,
    output logic [opet_pkg::TIME_W-1:0]  m_next_expire,
    output logic [opet_pkg::TIME_W-1:0]  m_period_out
);

    opet_pkg::cmd_t  cmd;
    opet_pkg::stat_t st;

    opet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    opet_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_action      (s_action),
        .s_now_time    (s_now_time),
        .s_base_time   (s_base_time),
        .s_period_in   (s_period_in),
        .m_status      (m_status),
        .m_event_fire  (m_event_fire),
        .m_event_src   (m_event_src),
        .m_event_d1    (m_event_d1),
        .m_event_d2    (m_event_d2),
        .m_event_time  (m_event_time),
        .m_sleep_hint  (m_sleep_hint),
        .m_running     (m_running),
        .m_next_expire (m_next_expire),
        .m_period_out  (m_period_out)
    );

endmodule

FILE: rtl/opet_mod.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module opet_mod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [opet_pkg::TIME_W-1:0]  dividend,
    input  logic [opet_pkg::TIME_W-1:0]  divisor,
    output logic                         done,
    output logic [opet_pkg::TIME_W-1:0]  remainder
);

    localparam int W = opet_pkg::TIME_W;

    logic [W-1:0]               rem_reg, rem_next;
    logic [W-1:0]               quo_reg, quo_next;
    logic [opet_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]                 part;
    logic [W+1:0]               diff;

    always_comb begin
        part     = {rem_reg, quo_reg[W-1]};
        diff     = {1'b0, part} - {2'b00, divisor};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = opet_pkg::CNT_W'(W);
        end else if (cnt_reg != '0) begin
            rem_next = diff[W+1] ? part[W-1:0] : diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg;

endmodule

FILE: rtl/opet_ctrl.sv
// Sequencing state machine for the event timer.
module opet_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  opet_pkg::stat_t  st,
    output opet_pkg::cmd_t   cmd
);

    opet_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            opet_pkg::S_IDLE: begin
                if (s_valid) state_next = opet_pkg::S_CHECK;
            end
            opet_pkg::S_CHECK: begin
                if (st.is_start && !st.rejected) state_next = opet_pkg::S_START;
                else state_next = opet_pkg::S_RESULT;
            end
            opet_pkg::S_START: begin
                if (st.need_phase) state_next = opet_pkg::S_FIRST;
                else state_next = opet_pkg::S_RESULT;
            end
            opet_pkg::S_FIRST: begin
                if (st.now_lt_first) state_next = opet_pkg::S_RESULT;
                else state_next = opet_pkg::S_MOD;
            end
            opet_pkg::S_MOD: begin
                if (st.div_done) state_next = opet_pkg::S_ALIGN;
            end
            opet_pkg::S_ALIGN: begin
                state_next = opet_pkg::S_FIXUP;
            end
            opet_pkg::S_FIXUP: begin
                state_next = opet_pkg::S_RESULT;
            end
            opet_pkg::S_RESULT: begin
                if (out_free) state_next = opet_pkg::S_IDLE;
            end
            default: begin
                state_next = opet_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            opet_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            opet_pkg::S_CHECK: begin
                cmd.check = 1'b1;
            end
            opet_pkg::S_START: begin
                cmd.start = 1'b1;
            end
            opet_pkg::S_FIRST: begin
                cmd.first     = 1'b1;
                cmd.div_start = !st.now_lt_first;
            end
            opet_pkg::S_ALIGN: begin
                cmd.align = 1'b1;
            end
            opet_pkg::S_FIXUP: begin
                cmd.fixup = 1'b1;
            end
            opet_pkg::S_RESULT: begin
                cmd.load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= opet_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/opet_dp.sv
// Timer state, configuration registers, arithmetic and result register.
module opet_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  opet_pkg::cmd_t               cmd,
    output opet_pkg::stat_t              st,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [opet_pkg::TIME_W-1:0]  cfg_wr_data,
    input  logic [1:0]                   s_action,
    input  logic [opet_pkg::TIME_W-1:0]  s_now_time,
    input  logic [opet_pkg::TIME_W-1:0]  s_base_time,
    input  logic [opet_pkg::TIME_W-1:0]  s_period_in,
    output logic [2:0]                   m_status,
    output logic                         m_event_fire,
    output logic [opet_pkg::TIME_W-1:0]  m_event_src,
    output logic [opet_pkg::TIME_W-1:0]  m_event_d1,
    output logic [opet_pkg::TIME_W-1:0]  m_event_d2,
    output logic [opet_pkg::TIME_W-1:0]  m_event_time,
    output logic [opet_pkg::TIME_W-1:0]  m_sleep_hint,
    output logic                         m_running,
    output logic [opet_pkg::TIME_W-1:0]  m_next_expire,
    output logic [opet_pkg::TIME_W-1:0]  m_period_out
);

    localparam int W = opet_pkg::TIME_W;

    logic         conn_reg, conn_next;
    logic [W-1:0] src_reg, src_next;
    logic [W-1:0] d1_reg, d1_next;
    logic [W-1:0] d2_reg, d2_next;

    logic         run_reg, run_next;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] per_v_reg, per_v_next;

    logic [1:0]   act_reg, act_next;
    logic [W-1:0] now_reg, now_next;
    logic [W-1:0] base_reg, base_next;
    logic [W-1:0] per_reg, per_next;
    logic [W-1:0] tmp_reg, tmp_next;
    logic [2:0]   stat_reg, stat_next;
    logic         fired_reg, fired_next;
    logic [W-1:0] fat_reg, fat_next;

    logic [2:0]   o_stat_reg, o_stat_next;
    logic         o_fire_reg, o_fire_next;
    logic [W-1:0] o_src_reg, o_src_next;
    logic [W-1:0] o_d1_reg, o_d1_next;
    logic [W-1:0] o_d2_reg, o_d2_next;
    logic [W-1:0] o_time_reg, o_time_next;
    logic [W-1:0] o_sleep_reg, o_sleep_next;
    logic         o_run_reg, o_run_next;
    logic [W-1:0] o_exp_reg, o_exp_next;
    logic [W-1:0] o_per_reg, o_per_next;

    logic         inval;
    logic         done_now, done_base;
    logic [W-1:0] rem_now, rem_base;

    opet_mod u_mod_now (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (now_reg),
        .divisor   (per_reg),
        .done      (done_now),
        .remainder (rem_now)
    );

    opet_mod u_mod_base (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (base_reg),
        .divisor   (per_reg),
        .done      (done_base),
        .remainder (rem_base)
    );

    assign inval = (per_reg != '0) && (per_reg < opet_pkg::MIN_PERIOD);

    always_comb begin
        st.is_start     = (act_reg == opet_pkg::ACT_START);
        st.rejected     = inval || !conn_reg;
        st.need_phase   = !run_reg && (per_reg != '0) && (base_reg != '0);
        st.now_lt_first = (now_reg < tmp_reg);
        st.div_done     = done_now && done_base;
    end

    always_comb begin
        conn_next = conn_reg;
        src_next  = src_reg;
        d1_next   = d1_reg;
        d2_next   = d2_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                opet_pkg::CFG_PORT_CONNECTED: conn_next = cfg_wr_data[0];
                opet_pkg::CFG_EVENT_SOURCE:   src_next  = cfg_wr_data;
                opet_pkg::CFG_EVENT_DATA_ONE: d1_next   = cfg_wr_data;
                opet_pkg::CFG_EVENT_DATA_TWO: d2_next   = cfg_wr_data;
                default: conn_next = conn_reg;
            endcase
        end
    end

    always_comb begin
        run_next   = run_reg;
        exp_next   = exp_reg;
        per_v_next = per_v_reg;
        act_next   = act_reg;
        now_next   = now_reg;
        base_next  = base_reg;
        per_next   = per_reg;
        tmp_next   = tmp_reg;
        stat_next  = stat_reg;
        fired_next = fired_reg;
        fat_next   = fat_reg;

        if (cmd.capture) begin
            act_next   = s_action;
            now_next   = s_now_time;
            base_next  = s_base_time;
            per_next   = s_period_in;
            stat_next  = opet_pkg::STAT_OK;
            fired_next = 1'b0;
            fat_next   = '0;
        end

        if (cmd.check) begin
            if (st.is_start && inval) begin
                stat_next = opet_pkg::STAT_INVAL;
            end else if (st.is_start && !conn_reg) begin
                stat_next = opet_pkg::STAT_NOTCONN;
            end else begin
                if (run_reg && (now_reg >= exp_reg)) begin
                    fired_next = conn_reg;
                    fat_next   = exp_reg;
                    if (per_v_reg != '0) exp_next = opet_pkg::sat_add(exp_reg, per_v_reg);
                    else run_next = 1'b0;
                end
                if (act_reg == opet_pkg::ACT_STOP) run_next = 1'b0;
            end
        end

        if (cmd.start) begin
            if (run_reg) begin
                stat_next = opet_pkg::STAT_BUSY;
            end else if (per_reg == '0) begin
                if (now_reg >= base_reg) begin
                    stat_next = opet_pkg::STAT_PAST;
                end else begin
                    exp_next   = base_reg;
                    per_v_next = per_reg;
                    run_next   = 1'b1;
                end
            end else if (base_reg == '0) begin
                exp_next   = opet_pkg::sat_add(now_reg, per_reg);
                per_v_next = per_reg;
                run_next   = 1'b1;
            end else begin
                tmp_next = opet_pkg::sat_add(base_reg, per_reg);
            end
        end

        if (cmd.first && st.now_lt_first) begin
            exp_next   = tmp_reg;
            per_v_next = per_reg;
            run_next   = 1'b1;
        end

        if (cmd.align) begin
            tmp_next = opet_pkg::sat_add(now_reg - rem_now, rem_base);
        end

        if (cmd.fixup) begin
            exp_next   = opet_pkg::sat_add(tmp_reg, (tmp_reg < now_reg) ? per_reg : '0);
            per_v_next = per_reg;
            run_next   = 1'b1;
        end
    end

    always_comb begin
        o_stat_next  = o_stat_reg;
        o_fire_next  = o_fire_reg;
        o_src_next   = o_src_reg;
        o_d1_next    = o_d1_reg;
        o_d2_next    = o_d2_reg;
        o_time_next  = o_time_reg;
        o_sleep_next = o_sleep_reg;
        o_run_next   = o_run_reg;
        o_exp_next   = o_exp_reg;
        o_per_next   = o_per_reg;
        if (cmd.load) begin
            o_stat_next  = stat_reg;
            o_fire_next  = fired_reg;
            o_src_next   = fired_reg ? src_reg : '0;
            o_d1_next    = fired_reg ? d1_reg : '0;
            o_d2_next    = fired_reg ? d2_reg : '0;
            o_time_next  = fired_reg ? fat_reg : '0;
            o_sleep_next = run_reg ? opet_pkg::sat_sub(exp_reg, now_reg) : {W{1'b1}};
            o_run_next   = run_reg;
            o_exp_next   = exp_reg;
            o_per_next   = per_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conn_reg  <= 1'b0;
            src_reg   <= '0;
            d1_reg    <= '0;
            d2_reg    <= '0;
            run_reg   <= 1'b0;
            exp_reg   <= '0;
            per_v_reg <= '0;
        end else begin
            conn_reg  <= conn_next;
            src_reg   <= src_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            run_reg   <= run_next;
            exp_reg   <= exp_next;
            per_v_reg <= per_v_next;
        end
        act_reg     <= act_next;
        now_reg     <= now_next;
        base_reg    <= base_next;
        per_reg     <= per_next;
        tmp_reg     <= tmp_next;
        stat_reg    <= stat_next;
        fired_reg   <= fired_next;
        fat_reg     <= fat_next;
        o_stat_reg  <= o_stat_next;
        o_fire_reg  <= o_fire_next;
        o_src_reg   <= o_src_next;
        o_d1_reg    <= o_d1_next;
        o_d2_reg    <= o_d2_next;
        o_time_reg  <= o_time_next;
        o_sleep_reg <= o_sleep_next;
        o_run_reg   <= o_run_next;
        o_exp_reg   <= o_exp_next;
        o_per_reg   <= o_per_next;
    end

    assign m_status      = o_stat_reg;
    assign m_event_fire  = o_fire_reg;
    assign m_event_src   = o_src_reg;
    assign m_event_d1    = o_d1_reg;
    assign m_event_d2    = o_d2_reg;
    assign m_event_time  = o_time_reg;
    assign m_sleep_hint  = o_sleep_reg;
    assign m_running     = o_run_reg;
    assign m_next_expire = o_exp_reg;
    assign m_period_out  = o_per_reg;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the one-shot/periodic event timer.
`timescale 1ns / 1ps

module tb;

    localparam int TIME_W       = opet_pkg::TIME_W;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 88;
    localparam int PHASES       = 8;
    localparam logic [TIME_W-1:0] ONES = {TIME_W{1'b1}};

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] period;
    } timer_cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic              fire;
        logic [TIME_W-1:0] src;
        logic [TIME_W-1:0] d1;
        logic [TIME_W-1:0] d2;
        logic [TIME_W-1:0] fired_at;
        logic [TIME_W-1:0] sleep;
        logic              running;
        logic [TIME_W-1:0] expire;
        logic [TIME_W-1:0] period;
    } timer_report_t;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [1:0]        cfg_index   = opet_pkg::CFG_PORT_CONNECTED;
    logic [TIME_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [1:0]        s_action    = opet_pkg::ACT_TICK;
    logic [TIME_W-1:0] s_now_time  = '0;
    logic [TIME_W-1:0] s_base_time = '0;
    logic [TIME_W-1:0] s_period_in = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [2:0]        m_status;
    logic              m_event_fire;
    logic [TIME_W-1:0] m_event_src;
    logic [TIME_W-1:0] m_event_d1;
    logic [TIME_W-1:0] m_event_d2;
    logic [TIME_W-1:0] m_event_time;
    logic [TIME_W-1:0] m_sleep_hint;
    logic              m_running;
    logic [TIME_W-1:0] m_next_expire;
    logic [TIME_W-1:0] m_period_out;

    oneshot_periodic_event_timer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_now_time    (s_now_time),
        .s_base_time   (s_base_time),
        .s_period_in   (s_period_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_event_fire  (m_event_fire),
        .m_event_src   (m_event_src),
        .m_event_d1    (m_event_d1),
        .m_event_d2    (m_event_d2),
        .m_event_time  (m_event_time),
        .m_sleep_hint  (m_sleep_hint),
        .m_running     (m_running),
        .m_next_expire (m_next_expire),
        .m_period_out  (m_period_out)
    );

    timer_cmd_t    pending_cmds[$];
    timer_report_t owed_reports[$];

    logic              cfg_conn;
    logic [TIME_W-1:0] cfg_src, cfg_d1, cfg_d2;
    logic              tmr_run;
    logic [TIME_W-1:0] tmr_expire, tmr_period;

    logic              no_idle    = 1'b0;
    int                hold_token = 0;
    int                hold_seen  = 0;
    int                hold_left  = 0;
    int                stall_left = 0;
    int                gap_left   = 0;
    int                mism_cnt   = 0;
    timer_cmd_t        cur_cmd;
    timer_report_t     got_report, want_report;
    logic [TIME_W-1:0] gnow;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [TIME_W-1:0] add_clamp(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? ONES : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] rnd(input int unsigned lo, input int unsigned hi);
        return TIME_W'($urandom_range(hi, lo));
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [TIME_W-1:0] phase_expiry(input logic [TIME_W-1:0] now,
                                                       input logic [TIME_W-1:0] base,
                                                       input logic [TIME_W-1:0] per);
        logic [TIME_W-1:0] first, aligned;
        if (base == '0) return add_clamp(now, per);
        first = add_clamp(base, per);
        if (now < first) return first;
        aligned = add_clamp(now - (now % per), base % per);
        return add_clamp(aligned, (aligned < now) ? per : '0);
    endfunction

    function automatic timer_report_t advance_timer(input timer_cmd_t c);
        timer_report_t r;
        logic          checked;
        r        = '0;
        r.status = opet_pkg::STAT_OK;
        checked  = 1'b1;
        if (c.action == opet_pkg::ACT_START) begin
            if (c.period != '0 && c.period < opet_pkg::MIN_PERIOD) begin
                r.status = opet_pkg::STAT_INVAL;
                checked  = 1'b0;
            end else if (!cfg_conn) begin
                r.status = opet_pkg::STAT_NOTCONN;
                checked  = 1'b0;
            end
        end
        if (checked && tmr_run && c.now >= tmr_expire) begin
            if (cfg_conn) begin
                r.fire     = 1'b1;
                r.src      = cfg_src;
                r.d1       = cfg_d1;
                r.d2       = cfg_d2;
                r.fired_at = tmr_expire;
            end
            if (tmr_period != '0) tmr_expire = add_clamp(tmr_expire, tmr_period);
            else tmr_run = 1'b0;
        end
        if (c.action == opet_pkg::ACT_START && checked) begin
            if (tmr_run) begin
                r.status = opet_pkg::STAT_BUSY;
            end else if (c.period == '0 && c.now >= c.base) begin
                r.status = opet_pkg::STAT_PAST;
            end else begin
                tmr_expire = (c.period == '0) ? c.base : phase_expiry(c.now, c.base, c.period);
                tmr_period = c.period;
                tmr_run    = 1'b1;
            end
        end else if (c.action == opet_pkg::ACT_STOP) begin
            tmr_run = 1'b0;
        end
        r.sleep   = !tmr_run ? ONES : (tmr_expire > c.now) ? tmr_expire - c.now : '0;
        r.running = tmr_run;
        r.expire  = tmr_expire;
        r.period  = tmr_period;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mism_cnt++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                owed_reports.push_back(advance_timer(cur_cmd));
                gap_left = no_idle ? 0 : idle_len();
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_valid     <= 1'b1;
                    s_action    <= cur_cmd.action;
                    s_now_time  <= cur_cmd.now;
                    s_base_time <= cur_cmd.base;
                    s_period_in <= cur_cmd.period;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (m_valid && m_ready) begin
                got_report = '{m_status, m_event_fire, m_event_src, m_event_d1, m_event_d2,
                               m_event_time, m_sleep_hint, m_running, m_next_expire,
                               m_period_out};
                if (owed_reports.size() == 0) begin
                    $error("result item with no expectation waiting");
                    mism_cnt++;
                end else begin
                    want_report = owed_reports.pop_front();
                    check_field("status", TIME_W'(want_report.status),
                                TIME_W'(got_report.status));
                    check_field("event_fire", TIME_W'(want_report.fire),
                                TIME_W'(got_report.fire));
                    check_field("event_src", want_report.src, got_report.src);
                    check_field("event_d1", want_report.d1, got_report.d1);
                    check_field("event_d2", want_report.d2, got_report.d2);
                    check_field("event_time", want_report.fired_at, got_report.fired_at);
                    check_field("sleep_hint", want_report.sleep, got_report.sleep);
                    check_field("running", TIME_W'(want_report.running),
                                TIME_W'(got_report.running));
                    check_field("next_expire", want_report.expire, got_report.expire);
                    check_field("period_out", want_report.period, got_report.period);
                end
                stall_left = no_idle ? 0 : idle_len();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] a, input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] base, input logic [TIME_W-1:0] per);
        pending_cmds.push_back('{a, now, base, per});
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TIME_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            opet_pkg::CFG_PORT_CONNECTED: cfg_conn = val[0];
            opet_pkg::CFG_EVENT_SOURCE:   cfg_src  = val;
            opet_pkg::CFG_EVENT_DATA_ONE: cfg_d1   = val;
            opet_pkg::CFG_EVENT_DATA_TWO: cfg_d2   = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [TIME_W-1:0] conn, input logic [TIME_W-1:0] src,
                                input logic [TIME_W-1:0] d1, input logic [TIME_W-1:0] d2);
        write_reg(opet_pkg::CFG_PORT_CONNECTED, conn);
        write_reg(opet_pkg::CFG_EVENT_SOURCE, src);
        write_reg(opet_pkg::CFG_EVENT_DATA_ONE, d1);
        write_reg(opet_pkg::CFG_EVENT_DATA_TWO, d2);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || owed_reports.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic gen_phase(input int n);
        int                kind, steps, span, r;
        logic [TIME_W-1:0] per_v, base_v;
        while (pending_cmds.size() < n) begin
            if ($urandom_range(0, 9) < 3) begin
                per_v = ($urandom_range(0, 1) != 0) ? rand64() : rnd(0, 150);
                queue_cmd(2'($urandom_range(0, 3)), rand64(), rand64(), per_v);
            end else begin
                kind   = $urandom_range(0, 9);
                per_v  = rnd(100, 2000);
                base_v = '0;
                case (kind)
                    0, 1, 2, 3: begin
                        case ($urandom_range(0, 2))
                            0: base_v = '0;
                            1: base_v = gnow - rnd(0, 20000);
                            default: base_v = gnow + rnd(0, 3000);
                        endcase
                    end
                    4, 5: begin
                        per_v  = '0;
                        base_v = ($urandom_range(0, 4) == 0) ? gnow - rnd(0, 10)
                                                             : gnow + rnd(0, 5000);
                    end
                    6: begin
                        per_v  = rnd(1, 99);
                        base_v = rand64();
                    end
                    7: begin
                        per_v = rand64() >> $urandom_range(0, 56);
                        if (per_v < opet_pkg::MIN_PERIOD) per_v = per_v + opet_pkg::MIN_PERIOD;
                        base_v = rand64();
                        gnow   = rand64();
                    end
                    8: begin
                        gnow   = ONES - rnd(0, 5000);
                        base_v = ($urandom_range(0, 1) != 0) ? '0 : gnow - rnd(0, 9000);
                    end
                    default: begin
                        per_v  = opet_pkg::MIN_PERIOD;
                        base_v = gnow - rnd(0, 500);
                    end
                endcase
                if ($urandom_range(0, 1) != 0)
                    queue_cmd(opet_pkg::ACT_STOP, gnow, rand64(), rand64());
                queue_cmd(opet_pkg::ACT_START, gnow, base_v, per_v);
                steps = $urandom_range(2, 8);
                span  = (per_v == '0 || per_v > 2000) ? 3000 : 3 * int'(per_v);
                repeat (steps) begin
                    if ($urandom_range(0, 9) == 0) gnow = add_clamp(gnow, per_v);
                    else gnow = add_clamp(gnow, TIME_W'($urandom_range(0, span)));
                    r = $urandom_range(0, 9);
                    if (r < 6) queue_cmd(opet_pkg::ACT_TICK, gnow, rand64(), rand64());
                    else if (r < 8) queue_cmd(opet_pkg::ACT_READ, gnow, rand64(), rand64());
                    else if (r == 8) queue_cmd(opet_pkg::ACT_START, gnow, gnow + rnd(0, 900),
                                               TIME_W'($urandom_range(0, 1) * 500));
                    else queue_cmd(opet_pkg::ACT_STOP, gnow, rand64(), rand64());
                end
                if (gnow[TIME_W-1]) gnow = TIME_W'($urandom_range(0, 32'h00FF_FFFF));
            end
        end
    endtask

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("oneshot_periodic_event_timer verification failed");
        $finish;
    end

    initial begin
        cfg_conn   = 1'b0;
        cfg_src    = '0;
        cfg_d1     = '0;
        cfg_d2     = '0;
        tmr_run    = 1'b0;
        tmr_expire = '0;
        tmr_period = '0;
        gnow       = TIME_W'(30000);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        @(negedge aclk);
        queue_cmd(opet_pkg::ACT_TICK, '0, '0, '0);
        queue_cmd(opet_pkg::ACT_START, '0, TIME_W'(1000), TIME_W'(50));
        queue_cmd(opet_pkg::ACT_START, '0, TIME_W'(1000), '0);
        wait_drained();

        write_config(TIME_W'(1), ONES, '0, rand64());
        @(negedge aclk);
        queue_cmd(opet_pkg::ACT_READ, '0, ONES, ONES);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(500), TIME_W'(500), '0);
        queue_cmd(opet_pkg::ACT_START, '0, '0, '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(100), TIME_W'(1000), '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(200), TIME_W'(5000), TIME_W'(300));
        queue_cmd(opet_pkg::ACT_TICK, TIME_W'(999), '0, '0);
        queue_cmd(opet_pkg::ACT_TICK, TIME_W'(1000), '0, '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(2000), '0, TIME_W'(100));
        queue_cmd(opet_pkg::ACT_TICK, TIME_W'(2350), '0, '0);
        queue_cmd(opet_pkg::ACT_READ, TIME_W'(2350), '0, '0);
        queue_cmd(opet_pkg::ACT_STOP, TIME_W'(2400), '0, '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(4000), TIME_W'(5000), TIME_W'(300));
        queue_cmd(opet_pkg::ACT_STOP, TIME_W'(4100), '0, '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(10000), TIME_W'(1234), TIME_W'(1000));
        queue_cmd(opet_pkg::ACT_STOP, TIME_W'(10000), '0, '0);
        queue_cmd(opet_pkg::ACT_START, ONES - TIME_W'(255), '0, TIME_W'(1000));
        queue_cmd(opet_pkg::ACT_TICK, ONES, '0, '0);
        queue_cmd(opet_pkg::ACT_STOP, ONES, '0, '0);
        queue_cmd(opet_pkg::ACT_START, ONES, ONES, ONES);
        queue_cmd(opet_pkg::ACT_STOP, '0, '0, '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(20000), '0, TIME_W'(100));
        wait_drained();

        // disconnect with the periodic timer still armed
        write_config(rand64() << 1, cfg_src, cfg_d1, cfg_d2);
        @(negedge aclk);
        queue_cmd(opet_pkg::ACT_TICK, TIME_W'(20250), '0, '0);
        queue_cmd(opet_pkg::ACT_START, TIME_W'(20260), '0, '0);
        queue_cmd(opet_pkg::ACT_STOP, TIME_W'(20300), '0, '0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_config((p == 3) ? (rand64() << 1) : ((rand64() << 1) | TIME_W'(1)),
                         (p == 1) ? '0 : (p == 2) ? ONES : rand64(),
                         (p == 1) ? '0 : (p == 2) ? ONES : rand64(),
                         (p == 1) ? '0 : (p == 2) ? ONES : rand64());
            @(negedge aclk);
            no_idle = (p == 4);
            if (p == 5) hold_token++;
            gen_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (owed_reports.size() != 0)
            $error("%0d expected results never arrived", owed_reports.size());
        if (mism_cnt == 0 && owed_reports.size() == 0)
            $display("oneshot_periodic_event_timer verification clean");
        else
            $display("oneshot_periodic_event_timer verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/opet_pkg.sv
rtl/opet_mod.sv
rtl/opet_ctrl.sv
rtl/opet_dp.sv
rtl/oneshot_periodic_event_timer.sv
sim/tb.sv
